// ===== src/tts_pkg.sv =====
// Shared types and constants for the token scanner.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
  localparam int OFFSET_WIDTH = 32;

  localparam logic [2:0] K_CHAR       = 3'd0;
  localparam logic [2:0] K_CONTROL    = 3'd1;
  localparam logic [2:0] K_SPACE      = 3'd2;
  localparam logic [2:0] K_PAR        = 3'd3;
  localparam logic [2:0] K_END        = 3'd4;
  localparam logic [2:0] K_BADUTF     = 3'd5;
  localparam logic [2:0] K_INCOMPLETE = 3'd6;

  localparam logic [3:0] MODE_IDLE       = 4'd0;
  localparam logic [3:0] MODE_BLANK      = 4'd1;
  localparam logic [3:0] MODE_BACKSLASH  = 4'd2;
  localparam logic [3:0] MODE_WORD       = 4'd3;
  localparam logic [3:0] MODE_AFTER_WORD = 4'd4;
  localparam logic [3:0] MODE_CHAR       = 4'd5;
  localparam logic [3:0] MODE_SYMBOL     = 4'd6;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] cp;
    logic [31:0] rbegin;
    logic [31:0] rend;
    logic [31:0] name;
    logic        last;
  } tok_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  // Sequence length of a lead byte (0 if invalid).
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b < 8'h80) return 3'd1;
    if (b >= 8'hC2 && b <= 8'hDF) return 3'd2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3'd3;
    if (b >= 8'hF0 && b <= 8'hF4) return 3'd4;
    return 3'd0;
  endfunction

  function automatic logic [20:0] lead_bits(input logic [7:0] b);
    if (b < 8'h80) return {13'd0, b};
    if (b >= 8'hC2 && b <= 8'hDF) return {16'd0, b[4:0]};
    if (b >= 8'hE0 && b <= 8'hEF) return {17'd0, b[3:0]};
    if (b >= 8'hF0 && b <= 8'hF4) return {18'd0, b[2:0]};
    return 21'd0;
  endfunction
endpackage
`default_nettype wire

// ===== src/tex_token_scanner_unit.sv =====
// A token appears on the output in the cycle after the request that completes it.
// One request per cycle while m_tready holds; a request giving two tokens stalls input.
// All work is one combinational pass from state and request into a two-entry token queue.
// Reset (rst, synchronous, active high) clears scan state, offset and queue.
// An end request returns the scanner to its reset state so a new source starts at zero.
`timescale 1ns / 1ps
`default_nettype none
module tex_token_scanner_unit import tts_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // source_byte[7:0]
  input  wire logic         s_tuser,   // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata,   // codepoint[20:0], range_begin[52:21],
                                       // range_end[84:53], name_bytes[116:85], zero pad
  output logic [2:0]        m_tuser,   // token_kind
  output logic              m_tlast    // last_of_run
);
  localparam int OW = OFFSET_WIDTH;

  logic [OW-1:0] byte_offset, byte_offset_next;
  logic [3:0]    scan_mode, scan_mode_next;
  logic [OW-1:0] token_start, token_start_next;
  logic [OW-1:0] word_end, word_end_next;
  logic [1:0]    lec, lec_next;
  logic          acr, acr_next;
  logic [20:0]   acc, acc_next;
  logic [2:0]    seen, seen_next;
  logic [2:0]    expct, expct_next;
  logic          stopped, stopped_next;

  tok_t          q [2];
  logic [1:0]    qcnt;
  tok_t          res [2];
  logic [1:0]    n;

  logic          in_fire, out_fire;

  assign s_tready = (qcnt == 2'd0) || (qcnt == 2'd1 && m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign m_tvalid = qcnt != 2'd0;
  assign m_tdata  = {3'd0, q[0].name, q[0].rend, q[0].rbegin, q[0].cp};
  assign m_tuser  = q[0].kind;
  assign m_tlast  = q[0].last;

  always_comb begin
    logic [7:0]    b;
    logic [OW-1:0] p, bgn;
    logic          restart, ok;
    logic [7:0]    lo, hi;
    logic [2:0]    ln;
    logic [20:0]   lb, acc_upd;
    logic [2:0]    seen_upd;

    b = s_tdata;
    p = byte_offset;
    restart = 1'b0;
    bgn = '0;
    lo = 8'h80;
    hi = 8'hBF;
    ok = 1'b0;
    ln = lead_len(b);
    lb = lead_bits(b);
    acc_upd = '0;
    seen_upd = '0;
    n = 2'd0;
    res[0] = '0;
    res[1] = '0;

    byte_offset_next = byte_offset;
    scan_mode_next   = scan_mode;
    token_start_next = token_start;
    word_end_next    = word_end;
    lec_next         = lec;
    acr_next         = acr;
    acc_next         = acc;
    seen_next        = seen;
    expct_next       = expct;
    stopped_next     = stopped;

    bgn = token_start + ((scan_mode == MODE_SYMBOL) ? OW'(1) : OW'(0));

    if (s_tuser) begin
      // end of source: flush pending token, then END, then return to reset
      if (!stopped) begin
        unique case (scan_mode)
          MODE_BLANK: begin
            res[0] = '{(lec == 2'd2) ? K_PAR : K_SPACE, 21'd0, 32'(token_start), 32'(p),
                       32'd0, 1'b0};
            n = 2'd1;
          end
          MODE_AFTER_WORD: begin
            if (lec == 2'd2) begin
              res[0] = '{K_PAR, 21'd0, 32'(word_end), 32'(p), 32'd0, 1'b0};
              n = 2'd1;
            end
          end
          MODE_WORD: begin
            res[0] = '{K_CONTROL, 21'd0, 32'(token_start), 32'(p),
                       32'(p - token_start - OW'(1)), 1'b0};
            n = 2'd1;
          end
          MODE_BACKSLASH: begin
            res[0] = '{K_INCOMPLETE, 21'd0, 32'(token_start), 32'(p), 32'd0, 1'b0};
            n = 2'd1;
          end
          MODE_CHAR, MODE_SYMBOL: begin
            res[0] = '{K_BADUTF, 21'd0, 32'(bgn), 32'(bgn + OW'(seen)), 32'd0, 1'b0};
            n = 2'd1;
          end
          default: ;
        endcase
      end
      res[n[0]] = '{K_END, 21'd0, 32'(p), 32'(p), 32'd0, 1'b0};
      n = n + 2'd1;
      byte_offset_next = '0;
      scan_mode_next   = MODE_IDLE;
      token_start_next = '0;
      word_end_next    = '0;
      lec_next         = '0;
      acr_next         = 1'b0;
      acc_next         = '0;
      seen_next        = '0;
      expct_next       = '0;
      stopped_next     = 1'b0;
    end else begin
      byte_offset_next = p + OW'(1);
      if (!stopped) begin
        unique case (scan_mode)
          MODE_BLANK, MODE_AFTER_WORD: begin
            if (is_blank(b)) begin
              if (b == CH_LF) begin
                if (acr) acr_next = 1'b0;
                else if (lec != 2'd2) lec_next = lec + 2'd1;
              end else if (b == CH_CR) begin
                if (lec != 2'd2) lec_next = lec + 2'd1;
                acr_next = 1'b1;
              end else begin
                acr_next = 1'b0;
              end
            end else begin
              if (scan_mode == MODE_BLANK) begin
                res[0] = '{(lec == 2'd2) ? K_PAR : K_SPACE, 21'd0, 32'(token_start), 32'(p),
                           32'd0, 1'b0};
                n = 2'd1;
              end else if (lec == 2'd2) begin
                res[0] = '{K_PAR, 21'd0, 32'(word_end), 32'(p), 32'd0, 1'b0};
                n = 2'd1;
              end
              restart = 1'b1;
            end
          end
          MODE_WORD: begin
            if (!is_letter(b)) begin
              res[0] = '{K_CONTROL, 21'd0, 32'(token_start), 32'(p),
                         32'(p - token_start - OW'(1)), 1'b0};
              n = 2'd1;
              word_end_next = p;
              if (is_blank(b)) begin
                scan_mode_next = MODE_AFTER_WORD;
                lec_next = (b == CH_LF || b == CH_CR) ? 2'd1 : 2'd0;
                acr_next = b == CH_CR;
              end else begin
                restart = 1'b1;
              end
            end
          end
          MODE_BACKSLASH: begin
            if (is_letter(b)) begin
              scan_mode_next = MODE_WORD;
            end else if (ln == 3'd0) begin
              res[0] = '{K_BADUTF, 21'd0, 32'(p), 32'(p + OW'(1)), 32'd0, 1'b0};
              n = 2'd1;
              stopped_next = 1'b1;
              scan_mode_next = MODE_IDLE;
            end else if (ln == 3'd1) begin
              res[0] = '{K_CONTROL, 21'd0, 32'(token_start), 32'(p + OW'(1)), 32'd1, 1'b0};
              n = 2'd1;
              scan_mode_next = MODE_IDLE;
            end else begin
              acc_next = lb;
              seen_next = 3'd1;
              expct_next = ln;
              scan_mode_next = MODE_SYMBOL;
            end
          end
          MODE_CHAR, MODE_SYMBOL: begin
            // tighten the second-byte window against overlong, surrogate and range errors
            if (seen == 3'd1) begin
              if (expct == 3'd3 && acc == 21'h0) lo = 8'hA0;
              if (expct == 3'd3 && acc == 21'hD) hi = 8'h9F;
              if (expct == 3'd4 && acc == 21'h0) lo = 8'h90;
              if (expct == 3'd4 && acc == 21'h4) hi = 8'h8F;
            end
            ok = b >= lo && b <= hi;
            acc_upd = {acc[14:0], b[5:0]};
            seen_upd = seen + 3'd1;
            if (!ok) begin
              res[0] = '{K_BADUTF, 21'd0, 32'(bgn), 32'(bgn + OW'(seen)), 32'd0, 1'b0};
              n = 2'd1;
              stopped_next = 1'b1;
              scan_mode_next = MODE_IDLE;
            end else begin
              acc_next = acc_upd;
              seen_next = seen_upd;
              if (seen_upd >= expct) begin
                if (scan_mode == MODE_CHAR)
                  res[0] = '{K_CHAR, acc_upd, 32'(token_start), 32'(p + OW'(1)), 32'd0, 1'b0};
                else
                  res[0] = '{K_CONTROL, 21'd0, 32'(token_start), 32'(p + OW'(1)),
                             32'(seen_upd), 1'b0};
                n = 2'd1;
                scan_mode_next = MODE_IDLE;
              end
            end
          end
          default: restart = 1'b1;
        endcase

        if (restart) begin
          scan_mode_next = MODE_IDLE;
          if (b == CH_BSLASH) begin
            token_start_next = p;
            scan_mode_next = MODE_BACKSLASH;
          end else if (is_blank(b)) begin
            token_start_next = p;
            scan_mode_next = MODE_BLANK;
            lec_next = (b == CH_LF || b == CH_CR) ? 2'd1 : 2'd0;
            acr_next = b == CH_CR;
          end else if (ln == 3'd0) begin
            res[n[0]] = '{K_BADUTF, 21'd0, 32'(p), 32'(p + OW'(1)), 32'd0, 1'b0};
            n = n + 2'd1;
            stopped_next = 1'b1;
          end else if (ln == 3'd1) begin
            res[n[0]] = '{K_CHAR, lb, 32'(p), 32'(p + OW'(1)), 32'd0, 1'b0};
            n = n + 2'd1;
          end else begin
            token_start_next = p;
            acc_next = lb;
            seen_next = 3'd1;
            expct_next = ln;
            scan_mode_next = MODE_CHAR;
          end
        end
      end
    end

    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      scan_mode   <= MODE_IDLE;
      token_start <= '0;
      word_end    <= '0;
      lec         <= '0;
      acr         <= 1'b0;
      acc         <= '0;
      seen        <= '0;
      expct       <= '0;
      stopped     <= 1'b0;
      qcnt        <= '0;
    end else begin
      if (in_fire) begin
        byte_offset <= byte_offset_next;
        scan_mode   <= scan_mode_next;
        token_start <= token_start_next;
        word_end    <= word_end_next;
        lec         <= lec_next;
        acr         <= acr_next;
        acc         <= acc_next;
        seen        <= seen_next;
        expct       <= expct_next;
        stopped     <= stopped_next;
        qcnt        <= n;
      end else if (out_fire) begin
        qcnt <= qcnt - 2'd1;
      end
    end
  end

  // queue payload: load on request, advance on drain
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q[0] <= res[0];
      q[1] <= res[1];
    end else if (out_fire) begin
      q[0] <= q[1];
    end
  end

`ifndef ASSERT_OFF
  a_qcnt_range: assert property (@(posedge clk) disable iff (rst) qcnt != 2'd3)
    else $error("token queue overfilled");
  a_two_not_last: assert property (@(posedge clk) disable iff (rst)
    qcnt == 2'd2 |-> !m_tlast)
    else $error("first of two tokens marked last");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    qcnt == 2'd1 |-> m_tlast)
    else $error("lone queued token not marked last");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tuser |=> byte_offset == '0 && !stopped)
    else $error("end request did not reset scanner");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tex_token_scanner_unit_test.sv =====
// Self-checking testbench for the token scanner: directed table, random sources, scoreboard.
`timescale 1ns / 1ps
module tex_token_scanner_unit_test;
  import tts_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] cp;
    logic [31:0] rbegin;
    logic [31:0] rend;
    logic [31:0] name;
    logic        last;
  } token_t;

  typedef struct {
    logic       cmd;
    logic [7:0] b;
    logic       check_kind;  // typed-in expectation for the first token of the row
    logic [2:0] kind;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  tex_token_scanner_unit u_top (.*);

  // Scanner mirror state.
  logic [31:0] sc_pos, sc_start, sc_word_end;
  logic [3:0]  sc_mode;
  logic [1:0]  sc_lines;
  logic        sc_after_cr, sc_halted;
  logic [20:0] sc_acc;
  logic [2:0]  sc_seen, sc_need;

  token_t expected_tokens[$];
  token_t step_tokens[$];
  int     error_count;
  int     token_count;
  int     source_count;

  function automatic logic letter_byte(input logic [7:0] b);
    return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ);
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic [2:0] seq_len(input logic [7:0] b, output logic [20:0] bits);
    bits = 21'd0;
    if (b < 8'h80) begin bits = {13'd0, b}; return 3'd1; end
    if (b >= 8'hC2 && b <= 8'hDF) begin bits = {16'd0, b[4:0]}; return 3'd2; end
    if (b >= 8'hE0 && b <= 8'hEF) begin bits = {17'd0, b[3:0]}; return 3'd3; end
    if (b >= 8'hF0 && b <= 8'hF4) begin bits = {18'd0, b[2:0]}; return 3'd4; end
    return 3'd0;
  endfunction

  task automatic push_token(input logic [2:0] k, input logic [20:0] cp,
                            input logic [31:0] rb, input logic [31:0] re,
                            input logic [31:0] nm);
    token_t t;
    t = '{kind: k, cp: cp, rbegin: rb, rend: re, name: nm, last: 1'b0};
    step_tokens.push_back(t);
  endtask

  task automatic clear_scanner();
    sc_pos = 0; sc_start = 0; sc_word_end = 0; sc_mode = MODE_IDLE;
    sc_lines = 0; sc_after_cr = 0; sc_halted = 0;
    sc_acc = 0; sc_seen = 0; sc_need = 0;
  endtask

  task automatic count_blank(input logic [7:0] b);
    if (b == CH_LF) begin
      if (sc_after_cr) sc_after_cr = 0;
      else if (sc_lines < 2) sc_lines++;
    end else if (b == CH_CR) begin
      if (sc_lines < 2) sc_lines++;
      sc_after_cr = 1;
    end else begin
      sc_after_cr = 0;
    end
  endtask

  task automatic halt_on(input logic [31:0] rb, input logic [31:0] re);
    push_token(K_BADUTF, 0, rb, re, 0);
    sc_halted = 1;
    sc_mode = MODE_IDLE;
  endtask

  task automatic open_token(input logic [7:0] b, input logic [31:0] p);
    logic [20:0] bits;
    logic [2:0]  n;
    if (b == CH_BSLASH) begin
      sc_start = p; sc_mode = MODE_BACKSLASH;
    end else if (blank_byte(b)) begin
      sc_start = p; sc_mode = MODE_BLANK; sc_lines = 0; sc_after_cr = 0;
      count_blank(b);
    end else begin
      n = seq_len(b, bits);
      if (n == 0) halt_on(p, p + 1);
      else if (n == 1) push_token(K_CHAR, bits, p, p + 1, 0);
      else begin
        sc_start = p; sc_acc = bits; sc_seen = 1; sc_need = n; sc_mode = MODE_CHAR;
      end
    end
  endtask

  function automatic logic cont_valid(input logic [7:0] b);
    logic [7:0] lo, hi;
    lo = 8'h80; hi = 8'hBF;
    if (sc_seen == 1) begin
      if (sc_need == 3 && sc_acc == 0) lo = 8'hA0;
      if (sc_need == 3 && sc_acc == 21'hD) hi = 8'h9F;
      if (sc_need == 4 && sc_acc == 0) lo = 8'h90;
      if (sc_need == 4 && sc_acc == 21'h4) hi = 8'h8F;
    end
    return b >= lo && b <= hi;
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic [31:0] p);
    logic [20:0] bits;
    logic [2:0]  n;
    logic [31:0] first;
    case (sc_mode)
      MODE_BLANK: begin
        if (blank_byte(b)) begin count_blank(b); return; end
        push_token(sc_lines >= 2 ? K_PAR : K_SPACE, 0, sc_start, p, 0);
      end
      MODE_AFTER_WORD: begin
        if (blank_byte(b)) begin count_blank(b); return; end
        if (sc_lines >= 2) push_token(K_PAR, 0, sc_word_end, p, 0);
      end
      MODE_WORD: begin
        if (letter_byte(b)) return;
        push_token(K_CONTROL, 0, sc_start, p, p - sc_start - 1);
        sc_word_end = p;
        if (blank_byte(b)) begin
          sc_mode = MODE_AFTER_WORD; sc_lines = 0; sc_after_cr = 0;
          count_blank(b);
          return;
        end
      end
      MODE_BACKSLASH: begin
        if (letter_byte(b)) begin sc_mode = MODE_WORD; return; end
        n = seq_len(b, bits);
        if (n == 0) halt_on(p, p + 1);
        else if (n == 1) begin
          push_token(K_CONTROL, 0, sc_start, p + 1, 1);
          sc_mode = MODE_IDLE;
        end else begin
          sc_acc = bits; sc_seen = 1; sc_need = n; sc_mode = MODE_SYMBOL;
        end
        return;
      end
      MODE_CHAR, MODE_SYMBOL: begin
        first = sc_start + (sc_mode == MODE_SYMBOL ? 1 : 0);
        if (!cont_valid(b)) begin halt_on(first, first + sc_seen); return; end
        sc_acc = {sc_acc[14:0], b[5:0]};
        sc_seen++;
        if (sc_seen >= sc_need) begin
          if (sc_mode == MODE_CHAR) push_token(K_CHAR, sc_acc, sc_start, p + 1, 0);
          else push_token(K_CONTROL, 0, sc_start, p + 1, {29'd0, sc_seen});
          sc_mode = MODE_IDLE;
        end
        return;
      end
      default: ;
    endcase
    sc_mode = MODE_IDLE;
    open_token(b, p);
  endtask

  task automatic flush_source(input logic [31:0] p);
    logic [31:0] first;
    if (!sc_halted) begin
      case (sc_mode)
        MODE_BLANK: push_token(sc_lines >= 2 ? K_PAR : K_SPACE, 0, sc_start, p, 0);
        MODE_AFTER_WORD: if (sc_lines >= 2) push_token(K_PAR, 0, sc_word_end, p, 0);
        MODE_WORD: push_token(K_CONTROL, 0, sc_start, p, p - sc_start - 1);
        MODE_BACKSLASH: push_token(K_INCOMPLETE, 0, sc_start, p, 0);
        MODE_CHAR, MODE_SYMBOL: begin
          first = sc_start + (sc_mode == MODE_SYMBOL ? 1 : 0);
          push_token(K_BADUTF, 0, first, first + sc_seen, 0);
        end
        default: ;
      endcase
    end
    push_token(K_END, 0, p, p, 0);
  endtask

  // Predict the tokens of one request and queue them.
  task automatic predict_tokens(input logic cmd, input logic [7:0] b);
    step_tokens.delete();
    if (cmd) begin
      flush_source(sc_pos);
      clear_scanner();
      source_count++;
    end else begin
      if (!sc_halted) scan_byte(b, sc_pos);
      sc_pos++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: stall on a pseudo-random pattern, with quiet stretches.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 200) % 3 == 0) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    token_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = '{kind: m_tuser, cp: m_tdata[20:0], rbegin: m_tdata[52:21],
              rend: m_tdata[84:53], name: m_tdata[116:85], last: m_tlast};
      token_count++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind %0d", got.kind);
        error_count++;
      end else begin
        exp = expected_tokens.pop_front();
        if (got.kind !== exp.kind) begin
          $error("token_kind exp %0d got %0d", exp.kind, got.kind); error_count++;
        end
        if (got.cp !== exp.cp) begin
          $error("codepoint exp %0h got %0h", exp.cp, got.cp); error_count++;
        end
        if (got.rbegin !== exp.rbegin) begin
          $error("range_begin exp %0d got %0d", exp.rbegin, got.rbegin); error_count++;
        end
        if (got.rend !== exp.rend) begin
          $error("range_end exp %0d got %0d", exp.rend, got.rend); error_count++;
        end
        if (got.name !== exp.name) begin
          $error("name_bytes exp %0d got %0d", exp.name, got.name); error_count++;
        end
        if (got.last !== exp.last) begin
          $error("last_of_run exp %0d got %0d", exp.last, got.last); error_count++;
        end
      end
    end
  end

  // Hold the request until accepted, then predict it.
  task automatic send_request(input logic cmd, input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tokens(cmd, b);
  endtask

  task automatic idle_gap();
    int gap;
    if ($urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Random well-formed fragment, sometimes with noise.
  task automatic send_fragment();
    int sel, n, i;
    logic [7:0] blanks[4];
    blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    sel = $urandom_range(0, 11);
    case (sel)
      0, 1: begin
        send_request(1'b0, 8'($urandom_range(8'h21, 8'h7E)));
      end
      2, 3: begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin idle_gap(); send_request(1'b0, blanks[$urandom_range(0, 3)]); end
      end
      4, 5: begin
        send_request(1'b0, CH_BSLASH);
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          idle_gap();
          send_request(1'b0, $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                                 : 8'($urandom_range(8'h61, 8'h7A)));
        end
      end
      6: begin
        send_request(1'b0, 8'($urandom_range(8'hC2, 8'hDF)));
        idle_gap(); send_request(1'b0, cont_byte());
      end
      7: begin
        send_request(1'b0, 8'($urandom_range(8'hE1, 8'hEC)));
        idle_gap(); send_request(1'b0, cont_byte());
        idle_gap(); send_request(1'b0, cont_byte());
      end
      8: begin
        send_request(1'b0, 8'($urandom_range(8'hF1, 8'hF3)));
        for (i = 0; i < 3; i++) begin idle_gap(); send_request(1'b0, cont_byte()); end
      end
      9: begin
        send_request(1'b0, CH_BSLASH);
        idle_gap(); send_request(1'b0, 8'($urandom_range(0, 255)));
      end
      default: send_request(1'b0, 8'($urandom_range(0, 255)));
    endcase
  endtask

  stim_row_t directed[$];
  token_t    typed_first;

  task automatic add_row(input logic cmd, input logic [7:0] b,
                         input logic chk, input logic [2:0] k);
    stim_row_t r;
    r = '{cmd: cmd, b: b, check_kind: chk, kind: k};
    directed.push_back(r);
  endtask

  initial begin
    int before_cnt, drain;
    error_count = 0; token_count = 0; source_count = 0;
    clear_scanner();
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = 8'h00; s_tuser = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: end on empty source, char, blanks, par, word, symbols, errors.
    add_row(1, 8'hFF, 1, K_END);
    add_row(0, 8'h00, 1, K_CHAR);
    add_row(0, 8'h7F, 1, K_CHAR);
    add_row(0, CH_CR, 0, 0);
    add_row(0, CH_LF, 0, 0);
    add_row(0, CH_LF, 0, 0);
    add_row(0, CH_BSLASH, 1, K_PAR);
    add_row(0, 8'h41, 0, 0);
    add_row(0, 8'h7A, 0, 0);
    add_row(0, CH_TAB, 1, K_CONTROL);
    add_row(0, CH_BSLASH, 0, 0);
    add_row(0, 8'h25, 1, K_CONTROL);
    add_row(0, CH_BSLASH, 0, 0);
    add_row(0, 8'hF4, 0, 0);
    add_row(0, 8'h8F, 0, 0);
    add_row(0, 8'hBF, 0, 0);
    add_row(0, 8'hBF, 0, 0);
    add_row(0, 8'hE0, 0, 0);
    add_row(0, 8'h9F, 1, K_BADUTF);
    add_row(0, 8'h41, 0, 0);
    add_row(1, 8'h00, 1, K_END);
    add_row(0, CH_BSLASH, 0, 0);
    add_row(1, 8'h00, 1, K_INCOMPLETE);
    add_row(0, 8'hC0, 1, K_BADUTF);
    add_row(1, 8'h00, 1, K_END);

    foreach (directed[i]) begin
      send_request(directed[i].cmd, directed[i].b);
      if (directed[i].check_kind) begin
        if (step_tokens.size() == 0) begin
          $error("token_kind exp %0d got none", directed[i].kind);
          error_count++;
        end else begin
          typed_first = step_tokens[0];
          if (typed_first.kind !== directed[i].kind) begin
            $error("token_kind exp %0d got %0d", directed[i].kind, typed_first.kind);
            error_count++;
          end
        end
      end
    end

    // Random sources: mostly well-formed fragments, each ended by an end request.
    for (int n = 0; n < 480;) begin
      if ($urandom_range(0, 2) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if ($urandom_range(0, 12) == 0) begin
        send_request(1'b1, 8'($urandom_range(0, 255)));
        n++;
      end else begin
        before_cnt = sc_pos;
        send_fragment();
        n += sc_pos - before_cnt;
      end
    end
    send_request(1'b1, 8'h00);
    s_tvalid <= 1'b0;

    drain = 0;
    while (expected_tokens.size() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_tokens.size() > 0) begin
      $error("%0d tokens never arrived", expected_tokens.size());
      error_count++;
    end
    $display("Covered %0d sources, %0d tokens checked, directed and random bytes.",
             source_count, token_count);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
